@@ rtl/core/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU cache model: item
// layouts, command codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int ADDR_W     = 64;
	localparam int SIZE_W     = 8;
	localparam int CNT_W      = 32;
	localparam int IN_W       = 80;
	localparam int OUT_W      = 104;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_FETCH  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

	typedef struct packed {
		logic [5:0]        pad;
		logic [SIZE_W-1:0] access_size;
		logic [ADDR_W-1:0] address;
		logic [1:0]        cmd;
	} sacl_in_t;

	typedef struct packed {
		logic [3:0]       pad;
		logic [CNT_W-1:0] eviction_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] hit_total;
		logic             modify_hit;
		logic             eviction;
		logic             miss;
		logic             hit;
	} sacl_out_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic update;
	} sacl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic fetch;
	} sacl_stat_t;

endpackage

@@ rtl/core/sacl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sacl_ctrl
// Controller: clears the tag store after reset, takes one access, then runs
// the compare and update step (not on fetch) once the output register is free.
// ----------------------------------------------------------------------------
module sacl_ctrl
	import sacl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output sacl_cmd_t  cmd,
	input  sacl_stat_t stat
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   accept;
	logic   upd;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign upd      = (state_q == ST_UPDATE) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;

	assign cmd.clear   = (state_q == ST_CLEAR);
	assign cmd.capture = accept;
	assign cmd.update  = upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			m_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && !stat.fetch) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

@@ rtl/core/sacl_dp.sv @@
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: configuration registers, address split, set-row tag store with
// valid bits and LRU ranks, way compare, victim choice and running counters.
// ----------------------------------------------------------------------------
module sacl_dp
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_W-1:0]       in_data,
	input  sacl_cmd_t             cmd,
	output sacl_stat_t            stat,
	output logic [OUT_W-1:0]      out_data
);

	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	typedef logic [RW-1:0]     rank_t;
	typedef logic [ADDR_W-1:0] tag_t;

	// configuration
	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [4:0] boff_q;
	logic [3:0] sbits;
	logic [4:0] ways_eff;

	// address split
	sacl_in_t    in_item;
	logic [ADDR_W-1:0] shifted;
	logic [SW-1:0] smask;
	logic [SW-1:0] set_in;
	tag_t          tag_in;
	logic          fit_in;

	logic [SW-1:0] set_q;
	tag_t          tag_q;
	logic          fit_q;
	logic          mod_q;

	// tag store
	tag_t  [MAX_WAYS-1:0] tag_mem   [SETS];
	logic  [MAX_WAYS-1:0] valid_mem [SETS];
	rank_t [MAX_WAYS-1:0] rank_mem  [SETS];

	tag_t  [MAX_WAYS-1:0] rd_tag_q;
	logic  [MAX_WAYS-1:0] rd_valid_q;
	rank_t [MAX_WAYS-1:0] rd_rank_q;

	logic [SW-1:0] clr_addr_q;

	// compare and update
	logic [MAX_WAYS-1:0]  in_use;
	logic                 hit_found;
	rank_t                hit_way;
	logic                 inv_found;
	rank_t                inv_way;
	rank_t                victim;
	rank_t                touch_way;
	rank_t                touch_rank;
	rank_t                top_rank;
	tag_t  [MAX_WAYS-1:0] new_tag;
	logic  [MAX_WAYS-1:0] new_valid;
	rank_t [MAX_WAYS-1:0] new_rank;
	logic                 evict;

	logic          wr_en;
	logic [SW-1:0] wr_addr;
	tag_t  [MAX_WAYS-1:0] wr_tag;
	logic  [MAX_WAYS-1:0] wr_valid;
	rank_t [MAX_WAYS-1:0] wr_rank;

	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] evict_cnt_q;
	logic [CNT_W-1:0] hit_cnt_n;
	logic [CNT_W-1:0] miss_cnt_n;
	logic [CNT_W-1:0] evict_cnt_n;
	sacl_out_t        out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd0;
			ways_q     <= 4'd1;
			boff_q     <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:   set_bits_q <= cfg_data[2:0];
				REG_WAYS:       ways_q     <= cfg_data[3:0];
				REG_BLOCK_BITS: boff_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sbits    = (4'(set_bits_q) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
	                                                      : 4'(set_bits_q);
	assign ways_eff = (ways_q == 4'd0) ? 5'd1 :
	                  ((5'(ways_q) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_q));

	assign in_item = sacl_in_t'(in_data);
	assign shifted = in_item.address >> boff_q;
	assign smask   = ~({SW{1'b1}} << sbits);
	assign set_in  = shifted[SW-1:0] & smask;
	assign tag_in  = in_item.address >> (6'(boff_q) + 6'(sbits));
	assign fit_in  = (boff_q >= 5'd8) ||
	                 ({1'b0, in_item.access_size} <= (9'd1 << boff_q));

	assign stat.fetch      = (in_item.cmd == CMD_FETCH);
	assign stat.clear_done = (clr_addr_q == SW'(SETS - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= set_in;
			tag_q <= tag_in;
			fit_q <= fit_in;
			mod_q <= (in_item.cmd == CMD_MODIFY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_tag_q   <= tag_mem[set_in];
			rd_valid_q <= valid_mem[set_in];
			rd_rank_q  <= rank_mem[set_in];
		end
		if (wr_en) begin
			tag_mem[wr_addr]   <= wr_tag;
			valid_mem[wr_addr] <= wr_valid;
			rank_mem[wr_addr]  <= wr_rank;
		end
	end

	assign top_rank = RW'(ways_eff - 5'd1);

	always_comb begin
		hit_found = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			in_use[w] = (5'(w) < ways_eff);
			if (in_use[w] && rd_valid_q[w] && (rd_tag_q[w] == tag_q) && fit_q) begin
				hit_found = 1'b1;
				hit_way   = RW'(w);
			end
			if (in_use[w] && !rd_valid_q[w]) begin
				inv_found = 1'b1;
				inv_way   = RW'(w);
			end
		end
		victim = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && (rd_rank_q[victim] >= rd_rank_q[w])) victim = RW'(w);
		end
		touch_way  = hit_found ? hit_way : (inv_found ? inv_way : victim);
		touch_rank = rd_rank_q[touch_way];
		for (int w = 0; w < MAX_WAYS; w++) begin
			new_tag[w]   = rd_tag_q[w];
			new_valid[w] = rd_valid_q[w];
			new_rank[w]  = rd_rank_q[w];
			if (in_use[w]) begin
				if (RW'(w) == touch_way) begin
					new_rank[w] = top_rank;
				end else if (rd_rank_q[w] > touch_rank) begin
					new_rank[w] = rd_rank_q[w] - 1'b1;
				end
			end
			if (!hit_found && (RW'(w) == touch_way)) begin
				new_tag[w]   = tag_q;
				new_valid[w] = 1'b1;
			end
		end
	end

	assign evict = !hit_found && !inv_found;

	assign wr_en    = cmd.clear || cmd.update;
	assign wr_addr  = cmd.clear ? clr_addr_q : set_q;
	assign wr_tag   = cmd.clear ? '0 : new_tag;
	assign wr_valid = cmd.clear ? '0 : new_valid;
	assign wr_rank  = cmd.clear ? '0 : new_rank;

	assign hit_cnt_n   = hit_cnt_q + CNT_W'(hit_found) + CNT_W'(mod_q);
	assign miss_cnt_n  = miss_cnt_q + CNT_W'(!hit_found);
	assign evict_cnt_n = evict_cnt_q + CNT_W'(evict);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (cmd.update) begin
			hit_cnt_q   <= hit_cnt_n;
			miss_cnt_q  <= miss_cnt_n;
			evict_cnt_q <= evict_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q.pad            <= '0;
			out_q.hit            <= hit_found;
			out_q.miss           <= !hit_found;
			out_q.eviction       <= evict;
			out_q.modify_hit     <= mod_q;
			out_q.hit_total      <= hit_cnt_n;
			out_q.miss_total     <= miss_cnt_n;
			out_q.eviction_total <= evict_cnt_n;
		end
	end

	assign out_data = out_q;

endmodule

@@ rtl/core/set_assoc_lru_cache_sim.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache model with LRU replacement and hit/miss/eviction
// counters.
//
//   channel  | direction | contents
//   ---------+-----------+----------------------------------------------------
//   s_axis   | in        | one access: cmd, address, access_size
//   m_axis   | out       | hit, miss, eviction, modify_hit and running totals
//   cfg      | in        | set index bits, ways in use, byte offset bits
//
// An access reads the set row from the tag store as the item is accepted;
// then all ways in use are compared and the row is written back.
// An instruction fetch is accepted but gives no result.
// After reset a clearing pass over every set row runs with s_tready low.
// A finished result waits in the output register; the compare step holds
// while that register is still full.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // cmd[1:0], address[65:2], access_size[73:66]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // hit[0], miss[1], eviction[2], modify_hit[3],
	                                         // hit_total[35:4], miss_total[67:36],
	                                         // eviction_total[99:68]
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	sacl_cmd_t  cmd;
	sacl_stat_t stat;

	sacl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	sacl_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache model. A short table
// of directed accesses and register writes comes first, then random accesses
// under several cache geometries. Every result is compared field by field
// with a local model of the tag store, ranks and counters. Idling on both
// stream sides and one long output hold are part of the run.
// ----------------------------------------------------------------------------
module tb_top;
	import sacl_pkg::*;

	localparam int SET_LIMIT       = 6;
	localparam int WAY_LIMIT       = 8;
	localparam int SETS            = 1 << SET_LIMIT;
	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ACCESSES_PER_GEOMETRY = 73;
	localparam int DIRECTED_ROWS   = 30;
	localparam int GEOMETRIES      = 8;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_STORE = 2'd1;

	// typed result: {typed, hit, miss, eviction}
	localparam logic [3:0] RES_MODEL = 4'b0000;
	localparam logic [3:0] RES_HIT   = 4'b1100;
	localparam logic [3:0] RES_MISS  = 4'b1010;
	localparam logic [3:0] RES_EVICT = 4'b1011;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FIVES    = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TENS     = 64'hAAAA_AAAA_AAAA_AAAA;

	typedef struct packed {
		logic                 is_reg;
		logic [1:0]           sel;
		logic [63:0]          addr;
		logic [7:0]           arg;
		logic [3:0]           typed_res;
	} stim_row_t;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [3:0] ways;
		logic [4:0] block_bits;
	} geometry_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b0, CMD_LOAD,       64'h0,           8'd1,   RES_MISS},
		'{1'b0, CMD_LOAD,       64'h0,           8'd1,   RES_HIT},
		'{1'b0, CMD_LOAD,       64'h0,           8'd2,   RES_EVICT},
		'{1'b0, CMD_STORE,      64'h0,           8'd0,   RES_HIT},
		'{1'b0, CMD_MODIFY,     64'h0,           8'd1,   RES_HIT},
		'{1'b0, CMD_FETCH,      64'h1,           8'd0,   RES_MODEL},
		'{1'b0, CMD_LOAD,       ALL_ONES,        8'd255, RES_EVICT},
		'{1'b1, REG_WAYS,       64'h0,           8'd0,   RES_MODEL},
		'{1'b0, CMD_LOAD,       ALL_ONES,        8'd1,   RES_HIT},
		'{1'b0, CMD_MODIFY,     FIVES,           8'd1,   RES_EVICT},
		'{1'b1, REG_WAYS,       64'h0,           8'd2,   RES_MODEL},
		'{1'b0, CMD_LOAD,       TENS,            8'd1,   RES_MISS},
		'{1'b1, REG_WAYS,       64'h0,           8'd3,   RES_MODEL},
		'{1'b0, CMD_LOAD,       64'h1234,        8'd1,   RES_MISS},
		'{1'b0, CMD_STORE,      64'h77,          8'd1,   RES_EVICT},
		'{1'b0, CMD_LOAD,       FIVES,           8'd1,   RES_HIT},
		'{1'b0, CMD_LOAD,       TENS,            8'd1,   RES_EVICT},
		'{1'b1, REG_SET_BITS,   64'h0,           8'd7,   RES_MODEL},
		'{1'b1, REG_WAYS,       64'h0,           8'd15,  RES_MODEL},
		'{1'b1, REG_BLOCK_BITS, 64'h0,           8'd31,  RES_MODEL},
		'{1'b0, CMD_LOAD,       64'h0,           8'd255, RES_MODEL},
		'{1'b0, CMD_STORE,      64'h7FFF_FFFF,   8'd255, RES_HIT},
		'{1'b0, CMD_MODIFY,     64'h8000_0000,   8'd128, RES_MODEL},
		'{1'b0, CMD_LOAD,       ALL_ONES,        8'd255, RES_MODEL},
		'{1'b0, CMD_FETCH,      ALL_ONES,        8'd255, RES_MODEL},
		'{1'b1, REG_BLOCK_BITS, 64'h0,           8'd16,  RES_MODEL},
		'{1'b1, REG_WAYS,       64'h0,           8'd8,   RES_MODEL},
		'{1'b1, REG_SET_BITS,   64'h0,           8'd6,   RES_MODEL},
		'{1'b0, CMD_LOAD,       64'h1_0000,      8'd255, RES_MODEL},
		'{1'b0, CMD_MODIFY,     64'h40_0000,     8'd0,   RES_MODEL}
	};

	localparam geometry_t GEOMETRY_PLAN [GEOMETRIES] = '{
		'{3'd2, 4'd4,  5'd4},
		'{3'd7, 4'd15, 5'd31},
		'{3'd3, 4'd2,  5'd6},
		'{3'd0, 4'd0,  5'd0},
		'{3'd6, 4'd8,  5'd16},
		'{3'd1, 4'd3,  5'd2},
		'{3'd5, 4'd9,  5'd3},
		'{3'd4, 4'd6,  5'd1}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SET_BITS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [63:0] line_tag   [SETS][WAY_LIMIT];
	bit          line_valid [SETS][WAY_LIMIT];
	bit   [2:0]  line_rank  [SETS][WAY_LIMIT];
	bit   [31:0] hit_count;
	bit   [31:0] miss_count;
	bit   [31:0] evict_count;
	bit   [2:0]  cfg_set_bits   = 3'd0;
	bit   [3:0]  cfg_ways       = 4'd1;
	bit   [4:0]  cfg_block_bits = 5'd0;

	sacl_out_t due_results [$];
	sacl_out_t seen;
	sacl_out_t want;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        snd_idle_pct = 37;
	int        rcv_idle_pct = 75;
	bit        hold_req = 1'b0;

	set_assoc_lru_cache_sim #(
		.MAX_SET_BITS(SET_LIMIT),
		.MAX_WAYS    (WAY_LIMIT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void promote_way(input int set, input int nways, input int way);
		bit [2:0] r;
		int       j;
		r = line_rank[set][way];
		for (j = 0; j < nways; j++) begin
			if (line_rank[set][j] > r)
				line_rank[set][j]--;
		end
		line_rank[set][way] = 3'(nways - 1);
	endfunction

	function automatic bit cache_lookup(input sacl_in_t acc, output sacl_out_t res);
		int          sb;
		int          nways;
		int          boff;
		int          set;
		int          victim;
		int          w;
		logic [63:0] tag;
		bit          found;
		bit          vacant;
		bit          picked;
		res = '0;
		if (acc.cmd == CMD_FETCH)
			return 1'b0;
		sb     = (int'(cfg_set_bits) > SET_LIMIT) ? SET_LIMIT : int'(cfg_set_bits);
		nways  = (cfg_ways == 0) ? 1
			: ((int'(cfg_ways) > WAY_LIMIT) ? WAY_LIMIT : int'(cfg_ways));
		boff   = int'(cfg_block_bits);
		set    = int'((acc.address >> boff) & ((64'd1 << sb) - 64'd1));
		tag    = acc.address >> (boff + sb);
		found  = 1'b0;
		vacant = 1'b0;
		for (w = 0; w < nways; w++) begin
			if (!found) begin
				if (line_valid[set][w]) begin
					if (line_tag[set][w] == tag && 64'(acc.access_size) <= (64'd1 << boff)) begin
						found = 1'b1;
						promote_way(set, nways, w);
					end
				end else begin
					vacant = 1'b1;
				end
			end
		end
		victim = 0;
		if (found) begin
			hit_count++;
		end else begin
			miss_count++;
			if (vacant) begin
				picked = 1'b0;
				for (w = 0; w < nways; w++) begin
					if (!picked && !line_valid[set][w]) begin
						victim = w;
						picked = 1'b1;
					end
				end
			end else begin
				evict_count++;
				for (w = 1; w < nways; w++) begin
					if (line_rank[set][victim] >= line_rank[set][w])
						victim = w;
				end
			end
			line_tag[set][victim]   = tag;
			line_valid[set][victim] = 1'b1;
			promote_way(set, nways, victim);
		end
		if (acc.cmd == CMD_MODIFY)
			hit_count++;
		res.hit            = found;
		res.miss           = !found;
		res.eviction       = !found && !vacant;
		res.modify_hit     = (acc.cmd == CMD_MODIFY);
		res.hit_total      = hit_count;
		res.miss_total     = miss_count;
		res.eviction_total = evict_count;
		return 1'b1;
	endfunction

	task automatic send_access(input sacl_in_t acc, input logic [3:0] typed_res);
		sacl_out_t res;
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = acc;
		do @(posedge clk); while (!s_tready);
		if (cache_lookup(acc, res)) begin
			if (typed_res[3])
				{res.hit, res.miss, res.eviction} = typed_res[2:0];
			due_results.push_back(res);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val[CFG_DATA_W-1:0];
		case (idx)
			REG_SET_BITS: begin
				cfg_set_bits = val[2:0];
			end
			REG_WAYS: begin
				cfg_ways = val[3:0];
			end
			REG_BLOCK_BITS: begin
				cfg_block_bits = val[4:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] expv, input logic [31:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen = sacl_out_t'(m_tdata);
			if (due_results.size() == 0) begin
				$error("result with no item pending: %h", m_tdata);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(seen.hit));
				check_field("miss", 32'(want.miss), 32'(seen.miss));
				check_field("eviction", 32'(want.eviction), 32'(seen.eviction));
				check_field("modify_hit", 32'(want.modify_hit), 32'(seen.modify_hit));
				check_field("hit_total", want.hit_total, seen.hit_total);
				check_field("miss_total", want.miss_total, seen.miss_total);
				check_field("eviction_total", want.eviction_total, seen.eviction_total);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			m_tready = ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	initial begin
		int          row;
		int          g;
		int          k;
		int          issued;
		int          eff_sb;
		int          eff_boff;
		int          size_cap;
		logic [63:0] hot_tag [8];
		logic [63:0] set_pick;
		logic [63:0] offset;
		sacl_in_t    acc;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (DIRECTED[row].is_reg) begin
				write_reg(DIRECTED[row].sel, DIRECTED[row].arg);
			end else begin
				acc             = '0;
				acc.cmd         = DIRECTED[row].sel;
				acc.address     = DIRECTED[row].addr;
				acc.access_size = DIRECTED[row].arg;
				send_access(acc, DIRECTED[row].typed_res);
			end
		end

		for (g = 0; g < GEOMETRIES; g++) begin
			if (g == 3) begin
				snd_idle_pct = 75;
				rcv_idle_pct = 37;
			end
			if (g == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			write_reg(REG_SET_BITS, 8'(GEOMETRY_PLAN[g].set_bits));
			write_reg(REG_WAYS, 8'(GEOMETRY_PLAN[g].ways));
			write_reg(REG_BLOCK_BITS, 8'(GEOMETRY_PLAN[g].block_bits));
			// hold the output side while items keep coming
			if (g == 6)
				hold_req = 1'b1;
			eff_sb   = (int'(GEOMETRY_PLAN[g].set_bits) > SET_LIMIT) ? SET_LIMIT
				: int'(GEOMETRY_PLAN[g].set_bits);
			eff_boff = int'(GEOMETRY_PLAN[g].block_bits);
			size_cap = (eff_boff >= 8) ? 255 : (1 << eff_boff);
			for (k = 0; k < 8; k++)
				hot_tag[k] = {$urandom, $urandom};
			issued = 0;
			while (issued < ACCESSES_PER_GEOMETRY) begin
				acc     = '0;
				acc.cmd = ($urandom_range(99) < 8) ? CMD_FETCH : 2'($urandom_range(2));
				if ($urandom_range(99) < 75) begin
					set_pick    = 64'($urandom_range(3));
					offset      = {$urandom, $urandom};
					acc.address = (hot_tag[$urandom_range(7)] << (eff_sb + eff_boff))
						| ((set_pick & ((64'd1 << eff_sb) - 64'd1)) << eff_boff)
						| (offset & ((64'd1 << eff_boff) - 64'd1));
				end else begin
					acc.address = {$urandom, $urandom};
				end
				if ($urandom_range(9) < 8)
					acc.access_size = 8'($urandom_range(size_cap));
				else
					acc.access_size = 8'($urandom_range(255));
				send_access(acc, RES_MODEL);
				if (acc.cmd != CMD_FETCH)
					issued++;
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
